@@ rtl/core/pkhga_pkg.sv @@
// Shared constants and types for the packed-key hash get-or-add block.
// Used by the front, back and top modules; depends on nothing.
package pkhga_pkg;

  localparam int unsigned GROUP_W     = 16;
  localparam int unsigned SUB_ID_BITS = 20;
  localparam int unsigned KEY_W       = GROUP_W + SUB_ID_BITS;
  localparam int unsigned NODE_W      = 10;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned OUT_DATA_W  = 16;
  localparam int unsigned OUT_USER_W  = 2;

  localparam logic [63:0] HASH_PRIME = 64'd1099511628211;
  localparam logic [SUB_ID_BITS-1:0] SUB_MASK = 20'hFFFFF;

  typedef struct packed {
    logic              table_full;
    logic              was_added;
    logic [NODE_W-1:0] node_id;
  } result_t;

endpackage

@@ rtl/core/packed_key_hash_get_or_add_top.sv @@
// Top level of the packed-key hash get-or-add block.
// Depends on pkhga_pkg, pkhga_front, pkhga_fifo and pkhga_back.
//
// Each input word carries a group index and a sub-id. They form a key that is
// looked up in a hash table with linear probing. A key already present returns
// its stored node id; a new key is stored with the next id from a running
// counter and comes back with was_added set. If the key is absent and every
// slot is taken, the result has table_full set and node id zero.
// The front end registers the hash, a two-entry queue decouples it from the
// probe engine, and the result sits in an output register, so input words keep
// being taken while a result waits. While probing, the probe engine reads one
// slot per cycle from its slot memory; it takes no new item from the queue
// until the current one has its result in the output register.
// After reset a sweep clears the slot-used memory, during which s_axis_tready_o
// stays low. When the receiver stalls, the result holds and the queue and the
// front register fill, after which s_axis_tready_o drops.
module packed_key_hash_get_or_add_top #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned GROUP_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // Fields from bit 0: group_index[15:0], sub_id[35:16], zero fill.
  input  logic [pkhga_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // Fields from bit 0: node_id[9:0], zero fill.
  output logic [pkhga_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // Fields from bit 0: was_added[0], table_full[1].
  output logic [pkhga_pkg::OUT_USER_W-1:0]  m_axis_tuser_o
);

  localparam int unsigned IdxW  = $clog2(TABLE_DEPTH);
  localparam int unsigned KeyW  = pkhga_pkg::KEY_W;
  localparam int unsigned GrpW  = pkhga_pkg::GROUP_W;
  localparam int unsigned SubW  = pkhga_pkg::SUB_ID_BITS;

  logic                   push_valid, push_ready;
  logic [IdxW+KeyW-1:0]   push_data;
  logic                   q_valid, q_ready;
  logic [IdxW+KeyW-1:0]   q_data;
  logic                   clearing;
  pkhga_pkg::result_t     res;

  pkhga_front #(
    .IDX_W      (IdxW),
    .GROUP_BITS (GROUP_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .group_index_i (s_axis_tdata_i[GrpW-1:0]),
    .sub_id_i      (s_axis_tdata_i[GrpW+SubW-1:GrpW]),
    .hold_i        (clearing),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  pkhga_fifo #(
    .WIDTH (IdxW + KeyW)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_data),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_data)
  );

  pkhga_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IdxW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_data_i    (q_data),
    .clearing_o  (clearing),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  assign m_axis_tdata_o = pkhga_pkg::OUT_DATA_W'(res.node_id);
  assign m_axis_tuser_o = {res.table_full, res.was_added};

endmodule

@@ rtl/core/pkhga_front.sv @@
// Front end: accepts input words, packs the key and hashes it into a slot index.
// Depends on pkhga_pkg; feeds the probe queue.
module pkhga_front #(
  parameter int unsigned IDX_W      = 10,
  parameter int unsigned GROUP_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [pkhga_pkg::GROUP_W-1:0]     group_index_i,
  input  logic [pkhga_pkg::SUB_ID_BITS-1:0] sub_id_i,
  input  logic                         hold_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output logic [IDX_W+pkhga_pkg::KEY_W-1:0] push_data_o
);

  localparam logic [pkhga_pkg::GROUP_W-1:0] GroupMask =
    (GROUP_BITS >= pkhga_pkg::GROUP_W) ? {pkhga_pkg::GROUP_W{1'b1}} :
    pkhga_pkg::GROUP_W'((32'd1 << GROUP_BITS) - 32'd1);
  localparam logic [15:0] PrimeLo = pkhga_pkg::HASH_PRIME[15:0];

  logic                          valid_q, valid_d;
  logic [pkhga_pkg::KEY_W-1:0]   key_q, key_d;
  logic [IDX_W-1:0]              idx_q, idx_d;
  logic [31:0]                   prod;
  logic                          accept;

  assign key_d  = {group_index_i & GroupMask, sub_id_i & pkhga_pkg::SUB_MASK};
  assign prod   = 32'(key_d[15:0]) * 32'(PrimeLo);
  assign idx_d  = prod[IDX_W-1:0];

  assign in_ready_o = (!valid_q || push_ready_i) && !hold_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= key_d;
      idx_q <= idx_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_data_o  = {idx_q, key_q};

endmodule

@@ rtl/core/pkhga_fifo.sv @@
// Two-entry queue between the hashing front end and the probe engine.
// Generic payload width; no package dependency.
module pkhga_fifo #(
  parameter int unsigned WIDTH = 46
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ rtl/core/pkhga_back.sv @@
// Probe engine: slot memories, clearing sweep, linear probe sequencer and result register.
// Depends on pkhga_pkg; takes hashed items from the queue.
module pkhga_back #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned IDX_W       = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  output logic                        q_ready_o,
  input  logic [IDX_W+pkhga_pkg::KEY_W-1:0] q_data_i,
  output logic                        clearing_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pkhga_pkg::result_t          out_res_o
);

  localparam int unsigned KeyW  = pkhga_pkg::KEY_W;
  localparam int unsigned NodeW = pkhga_pkg::NODE_W;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_CHECK = 3'b100
  } state_e;

  state_e                    state_q, state_d;
  logic [IDX_W-1:0]          clr_q, clr_d;
  logic [IDX_W-1:0]          probe_idx_q, probe_idx_d;
  logic [IDX_W-1:0]          probe_cnt_q, probe_cnt_d;
  logic [KeyW-1:0]           key_q, key_d;
  logic [pkhga_pkg::CNT_W-1:0] next_node_q, next_node_d;
  logic                      out_valid_q, out_valid_d;
  pkhga_pkg::result_t        out_res_q, out_res_d;

  logic                      used_mem [TABLE_DEPTH];
  logic [KeyW+NodeW-1:0]     data_mem [TABLE_DEPTH];
  logic                      used_rd_q;
  logic [KeyW+NodeW-1:0]     data_rd_q;

  logic [IDX_W-1:0]          rd_addr, wr_addr;
  logic                      used_we, used_wd, data_we;
  logic                      pop, key_hit, last_probe;
  logic [KeyW-1:0]           q_key;
  logic [IDX_W-1:0]          q_idx;

  assign q_key      = q_data_i[KeyW-1:0];
  assign q_idx      = q_data_i[IDX_W+KeyW-1:KeyW];
  assign pop        = (state_q == ST_IDLE) && q_valid_i && (!out_valid_q || out_ready_i);
  assign q_ready_o  = pop;
  assign key_hit    = used_rd_q && (data_rd_q[KeyW+NodeW-1:NodeW] == key_q);
  assign last_probe = (probe_cnt_q == {IDX_W{1'b1}});
  assign rd_addr    = (state_q == ST_CHECK) ? probe_idx_q + 1'b1 : q_idx;
  assign clearing_o = (state_q == ST_CLEAR);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    probe_idx_d = probe_idx_q;
    probe_cnt_d = probe_cnt_q;
    key_d       = key_q;
    next_node_d = next_node_q;
    out_res_d   = out_res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    used_we     = 1'b0;
    used_wd     = 1'b0;
    data_we     = 1'b0;
    wr_addr     = probe_idx_q;
    unique case (state_q)
      ST_CLEAR: begin
        used_we = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == {IDX_W{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          key_d       = q_key;
          probe_idx_d = q_idx;
          probe_cnt_d = '0;
          state_d     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!used_rd_q) begin
          used_we     = 1'b1;
          used_wd     = 1'b1;
          data_we     = 1'b1;
          out_res_d   = '{table_full: 1'b0, was_added: 1'b1,
                          node_id: next_node_q[NodeW-1:0]};
          out_valid_d = 1'b1;
          next_node_d = next_node_q + 1'b1;
          state_d     = ST_IDLE;
        end else if (key_hit) begin
          out_res_d   = '{table_full: 1'b0, was_added: 1'b0,
                          node_id: data_rd_q[NodeW-1:0]};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else if (last_probe) begin
          out_res_d   = '{table_full: 1'b1, was_added: 1'b0, node_id: '0};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          probe_idx_d = probe_idx_q + 1'b1;
          probe_cnt_d = probe_cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      next_node_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      next_node_q <= next_node_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_idx_q <= probe_idx_d;
    probe_cnt_q <= probe_cnt_d;
    key_q       <= key_d;
    out_res_q   <= out_res_d;
  end

  always_ff @(posedge clk_i) begin
    if (used_we) begin
      used_mem[wr_addr] <= used_wd;
    end
    used_rd_q <= used_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[wr_addr] <= {key_q, next_node_q[NodeW-1:0]};
    end
    data_rd_q <= data_mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  a_no_result_while_probing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |-> !out_valid_q)
    else $error("Result register occupied while a probe is in flight.");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_res_q.was_added && out_res_q.table_full))
    else $error("Result marked both added and full.");

  a_counter_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_node_q != $past(next_node_q)) |->
    $past(state_q == ST_CHECK && !used_rd_q))
    else $error("Node counter moved without an insert.");

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !q_ready_o)
    else $error("Item taken during the clearing sweep.");

endmodule
